@@ design/uart_rf_pkg.sv @@
package uart_rf_pkg;

  localparam int TX_DEPTH_DEF = 256;
  localparam int RX_DEPTH_DEF = 256;
  localparam int LVL_W        = 9;
  localparam int Q_DEPTH      = 4;

  typedef enum logic [2:0] {
    CMD_WRITE    = 3'd0,
    CMD_READ     = 3'd1,
    CMD_RX       = 3'd2,
    CMD_TX_EMPTY = 3'd3,
    CMD_TX_DONE  = 3'd4,
    CMD_CLR_TX   = 3'd5,
    CMD_CLR_RX   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RX_EMPTY = 2'd1,
    ST_TX_FULL  = 2'd2
  } status_t;

  // front to back: one classified item, store data follows in the next cycle
  typedef struct packed {
    logic             vld;
    status_t          status;
    logic             rx_pop;
    logic             tx_pop;
    logic             rx_new;
    logic             tx_done;
    logic             empty_en;
    logic             complete_en;
    logic             busy;
    logic [LVL_W-1:0] tx_level;
    logic [LVL_W-1:0] rx_level;
  } desc_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       read_byte;
    logic             line_tx_valid;
    logic [7:0]       line_tx_byte;
    logic             rx_new;
    logic             tx_done;
    logic             empty_en;
    logic             complete_en;
    logic             busy;
    logic [LVL_W-1:0] tx_level;
    logic [LVL_W-1:0] rx_level;
  } result_t;

  typedef struct packed {
    logic room;
  } back_stat_t;

endpackage

@@ design/uart_rf_ram.sv @@
module uart_rf_ram import uart_rf_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/uart_rf_front.sv @@
module uart_rf_front import uart_rf_pkg::*; #(
  parameter int TX_DEPTH = TX_DEPTH_DEF,
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [2:0]                  cmd,
  input  logic [7:0]                  data_byte,
  input  logic                        burst_end,
  input  back_stat_t                  bk_stat,
  output logic                        full,
  output desc_t                       desc,
  output logic                        tx_we,
  output logic [$clog2(TX_DEPTH)-1:0] tx_waddr,
  output logic                        tx_re,
  output logic [$clog2(TX_DEPTH)-1:0] tx_raddr,
  output logic                        rx_we,
  output logic [$clog2(RX_DEPTH)-1:0] rx_waddr,
  output logic                        rx_re,
  output logic [$clog2(RX_DEPTH)-1:0] rx_raddr,
  output logic [7:0]                  wdata
);

  localparam int TIW = $clog2(TX_DEPTH);
  localparam int RIW = $clog2(RX_DEPTH);
  localparam int TCW = $clog2(TX_DEPTH + 1);
  localparam int RCW = $clog2(RX_DEPTH + 1);

  logic [TIW-1:0] tx_wi_r, tx_wi_nxt, tx_ri_r, tx_ri_nxt;
  logic [RIW-1:0] rx_wi_r, rx_wi_nxt, rx_ri_r, rx_ri_nxt;
  logic [TCW-1:0] tx_cnt_r, tx_cnt_nxt;
  logic [RCW-1:0] rx_cnt_r, rx_cnt_nxt;
  logic           ee_r, ee_nxt, ce_r, ce_nxt, busy_r, busy_nxt;
  logic           acc, tx_full, rx_full, tx_zero, rx_zero, do_tx_pop;
  logic [TIW-1:0] tx_wi_inc, tx_ri_inc;
  logic [RIW-1:0] rx_wi_inc, rx_ri_inc;
  desc_t          d;

  assign full    = !bk_stat.room;
  assign acc     = push && !full;
  assign tx_full = (tx_cnt_r == TCW'(TX_DEPTH));
  assign rx_full = (rx_cnt_r == RCW'(RX_DEPTH));
  assign tx_zero = (tx_cnt_r == '0);
  assign rx_zero = (rx_cnt_r == '0);

  assign tx_wi_inc = (tx_wi_r == TIW'(TX_DEPTH - 1)) ? '0 : tx_wi_r + 1'b1;
  assign tx_ri_inc = (tx_ri_r == TIW'(TX_DEPTH - 1)) ? '0 : tx_ri_r + 1'b1;
  assign rx_wi_inc = (rx_wi_r == RIW'(RX_DEPTH - 1)) ? '0 : rx_wi_r + 1'b1;
  assign rx_ri_inc = (rx_ri_r == RIW'(RX_DEPTH - 1)) ? '0 : rx_ri_r + 1'b1;

  always_comb begin
    tx_wi_nxt  = tx_wi_r;
    tx_ri_nxt  = tx_ri_r;
    tx_cnt_nxt = tx_cnt_r;
    rx_wi_nxt  = rx_wi_r;
    rx_ri_nxt  = rx_ri_r;
    rx_cnt_nxt = rx_cnt_r;
    ee_nxt     = ee_r;
    ce_nxt     = ce_r;
    busy_nxt   = busy_r;
    d          = '0;
    do_tx_pop  = 1'b0;
    tx_we      = 1'b0;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    if (acc) begin
      d.vld = 1'b1;
      case (cmd_t'(cmd))
        CMD_WRITE: begin
          if (tx_full) begin
            d.status = ST_TX_FULL;
            ee_nxt   = 1'b1;
          end else begin
            tx_we      = 1'b1;
            tx_wi_nxt  = tx_wi_inc;
            tx_cnt_nxt = tx_cnt_r + 1'b1;
            if (burst_end) begin
              ee_nxt = 1'b1;
            end
          end
        end
        CMD_READ: begin
          if (rx_zero) begin
            d.status = ST_RX_EMPTY;
          end else begin
            rx_re      = 1'b1;
            d.rx_pop   = 1'b1;
            rx_ri_nxt  = rx_ri_inc;
            rx_cnt_nxt = rx_cnt_r - 1'b1;
          end
        end
        CMD_RX: begin
          rx_we     = 1'b1;
          rx_wi_nxt = rx_wi_inc;
          if (!rx_full) begin
            rx_cnt_nxt = rx_cnt_r + 1'b1;
          end
          d.rx_new = 1'b1;
        end
        CMD_TX_EMPTY: begin
          if (ee_r) begin
            if (tx_zero) begin
              ee_nxt = 1'b0;
              ce_nxt = 1'b1;
            end else begin
              busy_nxt  = 1'b1;
              do_tx_pop = 1'b1;
            end
          end
        end
        CMD_TX_DONE: begin
          if (ce_r) begin
            if (tx_zero) begin
              ce_nxt    = 1'b0;
              busy_nxt  = 1'b0;
              d.tx_done = 1'b1;
            end else begin
              do_tx_pop = 1'b1;
            end
          end
        end
        CMD_CLR_TX: begin
          tx_wi_nxt  = '0;
          tx_ri_nxt  = '0;
          tx_cnt_nxt = '0;
        end
        CMD_CLR_RX: begin
          rx_wi_nxt  = '0;
          rx_ri_nxt  = '0;
          rx_cnt_nxt = '0;
        end
        default: begin
        end
      endcase
      if (do_tx_pop) begin
        d.tx_pop   = 1'b1;
        tx_ri_nxt  = tx_ri_inc;
        tx_cnt_nxt = tx_cnt_r - 1'b1;
      end
      d.empty_en    = ee_nxt;
      d.complete_en = ce_nxt;
      d.busy        = busy_nxt;
      d.tx_level    = LVL_W'(tx_cnt_nxt);
      d.rx_level    = LVL_W'(rx_cnt_nxt);
    end
  end

  assign desc     = d;
  assign tx_re    = do_tx_pop;
  assign tx_waddr = tx_wi_r;
  assign tx_raddr = tx_ri_r;
  assign rx_waddr = rx_wi_r;
  assign rx_raddr = rx_ri_r;
  assign wdata    = data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wi_r  <= '0;
      tx_ri_r  <= '0;
      tx_cnt_r <= '0;
      rx_wi_r  <= '0;
      rx_ri_r  <= '0;
      rx_cnt_r <= '0;
      ee_r     <= 1'b0;
      ce_r     <= 1'b0;
      busy_r   <= 1'b0;
    end else begin
      tx_wi_r  <= tx_wi_nxt;
      tx_ri_r  <= tx_ri_nxt;
      tx_cnt_r <= tx_cnt_nxt;
      rx_wi_r  <= rx_wi_nxt;
      rx_ri_r  <= rx_ri_nxt;
      rx_cnt_r <= rx_cnt_nxt;
      ee_r     <= ee_nxt;
      ce_r     <= ce_nxt;
      busy_r   <= busy_nxt;
    end
  end

endmodule

@@ design/uart_rf_back.sv @@
module uart_rf_back import uart_rf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  desc_t      desc,
  input  logic [7:0] tx_rdata,
  input  logic [7:0] rx_rdata,
  input  logic       pop,
  output logic       empty,
  output result_t    res,
  output back_stat_t bk_stat
);

  localparam int QAW = $clog2(Q_DEPTH);
  localparam int QCW = $clog2(Q_DEPTH + 1);

  logic           stg_vld_r;
  desc_t          stg_r;
  result_t        q_r [Q_DEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic [QCW-1:0] occ;
  logic           do_pop;
  result_t        ent;

  // store read data arrives in the cycle after the item was classified
  always_comb begin
    ent.status        = stg_r.status;
    ent.read_byte     = stg_r.rx_pop ? rx_rdata : 8'd0;
    ent.line_tx_valid = stg_r.tx_pop;
    ent.line_tx_byte  = stg_r.tx_pop ? tx_rdata : 8'd0;
    ent.rx_new        = stg_r.rx_new;
    ent.tx_done       = stg_r.tx_done;
    ent.empty_en      = stg_r.empty_en;
    ent.complete_en   = stg_r.complete_en;
    ent.busy          = stg_r.busy;
    ent.tx_level      = stg_r.tx_level;
    ent.rx_level      = stg_r.rx_level;
  end

  assign empty        = (cnt_r == '0);
  assign do_pop       = pop && !empty;
  assign res          = q_r[rp_r];
  assign occ          = cnt_r + QCW'(stg_vld_r);
  assign bk_stat.room = (occ < QCW'(Q_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (stg_vld_r && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!stg_vld_r && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= desc;
    if (stg_vld_r) begin
      q_r[wp_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      wp_r      <= '0;
      rp_r      <= '0;
      cnt_r     <= '0;
    end else begin
      stg_vld_r <= desc.vld;
      cnt_r     <= cnt_nxt;
      if (stg_vld_r) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

endmodule

@@ design/uart_tx_rx_ring_fifo_core.sv @@
// serial port transmit / receive ring buffers, one command item per push
// input side: in_cmd, in_data_byte, in_burst_end are taken when in_push is
//   high and in_full is low; every item gives exactly one result item
// result side: the oldest result is on the out_ ports while out_empty is low
//   and leaves when out_pop is high; results come out in command order
// path: command and store access happen in the accepting cycle; the store
//   read and the item are then registered in the stage and written into the
//   result queue, whose head is on the out_ ports
// throughput: one item per cycle while in_full is low; the front updates
//   indices, counts and event enables as each item is taken and each store
//   has one write and one read port
// stall: a four-entry result queue sits behind the store stage; when the queue
//   and the stage hold four items between them, in_full rises and holds until
//   a result is popped
// reset (rst_n low, synchronous): indices, counts, enables, busy flag and the
//   result queue clear; the byte stores are not cleared, the counts keep
//   unwritten entries from being read
module uart_tx_rx_ring_fifo_core import uart_rf_pkg::*; #(
  parameter int TX_DEPTH = TX_DEPTH_DEF,
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [2:0]       in_cmd,
  input  logic [7:0]       in_data_byte,
  input  logic             in_burst_end,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [1:0]       out_status,
  output logic [7:0]       out_read_byte,
  output logic             out_line_tx_valid,
  output logic [7:0]       out_line_tx_byte,
  output logic             out_rx_new,
  output logic             out_tx_done,
  output logic             out_empty_event_enabled,
  output logic             out_complete_event_enabled,
  output logic             out_busy_sending,
  output logic [LVL_W-1:0] out_tx_level,
  output logic [LVL_W-1:0] out_rx_level
);

  localparam int TIW = $clog2(TX_DEPTH);
  localparam int RIW = $clog2(RX_DEPTH);

  desc_t          desc;
  back_stat_t     bk_stat;
  result_t        res;
  logic           tx_we, tx_re, rx_we, rx_re;
  logic [TIW-1:0] tx_waddr, tx_raddr;
  logic [RIW-1:0] rx_waddr, rx_raddr;
  logic [7:0]     wdata, tx_rdata, rx_rdata;

  uart_rf_front #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .cmd       (in_cmd),
    .data_byte (in_data_byte),
    .burst_end (in_burst_end),
    .bk_stat   (bk_stat),
    .full      (in_full),
    .desc      (desc),
    .tx_we     (tx_we),
    .tx_waddr  (tx_waddr),
    .tx_re     (tx_re),
    .tx_raddr  (tx_raddr),
    .rx_we     (rx_we),
    .rx_waddr  (rx_waddr),
    .rx_re     (rx_re),
    .rx_raddr  (rx_raddr),
    .wdata     (wdata)
  );

  uart_rf_ram #(
    .W     (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (wdata),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  uart_rf_ram #(
    .W     (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (wdata),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  uart_rf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .desc     (desc),
    .tx_rdata (tx_rdata),
    .rx_rdata (rx_rdata),
    .pop      (out_pop),
    .empty    (out_empty),
    .res      (res),
    .bk_stat  (bk_stat)
  );

  assign out_status                 = res.status;
  assign out_read_byte              = res.read_byte;
  assign out_line_tx_valid          = res.line_tx_valid;
  assign out_line_tx_byte           = res.line_tx_byte;
  assign out_rx_new                 = res.rx_new;
  assign out_tx_done                = res.tx_done;
  assign out_empty_event_enabled    = res.empty_en;
  assign out_complete_event_enabled = res.complete_en;
  assign out_busy_sending           = res.busy;
  assign out_tx_level               = res.tx_level;
  assign out_rx_level               = res.rx_level;

  a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
    desc.vld |-> !(desc.tx_pop && desc.rx_pop))
    else $error("item pops both rings");

  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |-> ##2 !out_empty)
    else $error("accepted item has no result after two cycles");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !(out_pop && !out_empty)) |=> in_full)
    else $error("full dropped without a result leaving");

  a_tx_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_line_tx_valid) |-> (out_status == ST_OK))
    else $error("line byte handed out with error status");

endmodule
